// ----- src/tbdp_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the thresholded binary dot popcount block
// no dependencies; used by every module under src

package tbdp_pkg;

  localparam int FIELD_LANES = 8;
  localparam int LANE_W = 8;
  localparam int FIELD_W = FIELD_LANES * LANE_W;
  localparam int COEF_W = 32;
  localparam int FRAC_BITS = 16;
  localparam int RESULT_W = 48;
  localparam int MATCH_W = 13;
  localparam int COUNT_W = 13;
  localparam int NLANE_W = 4;

  localparam int DEF_LANES = 8;
  localparam int DEF_MAX_ELEMENTS = 4096;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RESET = 13'd144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELEMENT_COUNT = 2'd0,
    REG_SCALE_ENABLE  = 2'd1,
    REG_RELU_ENABLE   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] element_count;
    logic               scale_enable;
    logic               relu_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] scale_value;
    logic signed [COEF_W-1:0] shift_value;
  } coef_t;

  typedef struct packed {
    logic [FIELD_W-1:0]       patch_bytes;
    logic [FIELD_W-1:0]       threshold_bytes;
    logic [FIELD_LANES-1:0]   weight_signs;
    logic [NLANE_W-1:0]       valid_lanes;
    logic                     last;
    logic signed [COEF_W-1:0] scale_value;
    logic signed [COEF_W-1:0] shift_value;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic [MATCH_W-1:0]         match_total;
  } out_item_t;

endpackage

// ----- src/tbdp_regs.sv -----
`timescale 1ns / 1ps
// apb register file: element count, scale enable, relu enable
// depends on tbdp_pkg

module tbdp_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbdp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tbdp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tbdp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output tbdp_pkg::cfg_t                  cfg
);

  logic [tbdp_pkg::CFG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[tbdp_pkg::CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.element_count <= tbdp_pkg::ELEMENT_COUNT_RESET;
      cfg.scale_enable  <= 1'b0;
      cfg.relu_enable   <= 1'b0;
    end else if (wr) begin
      case (idx)
        tbdp_pkg::REG_ELEMENT_COUNT: cfg.element_count <= pwdata[tbdp_pkg::COUNT_W-1:0];
        tbdp_pkg::REG_SCALE_ENABLE:  cfg.scale_enable  <= pwdata[0];
        tbdp_pkg::REG_RELU_ENABLE:   cfg.relu_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tbdp_pkg::REG_ELEMENT_COUNT:
        prdata = tbdp_pkg::CFG_DATA_W'(cfg.element_count);
      tbdp_pkg::REG_SCALE_ENABLE:
        prdata = tbdp_pkg::CFG_DATA_W'(cfg.scale_enable);
      tbdp_pkg::REG_RELU_ENABLE:
        prdata = tbdp_pkg::CFG_DATA_W'(cfg.relu_enable);
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- src/tbdp_lane.sv -----
`timescale 1ns / 1ps
// one lane: signed threshold compare, weight xor match, lane enable
// depends on tbdp_pkg for the lane width

module tbdp_lane (
  input  logic [tbdp_pkg::LANE_W-1:0] patch_byte,
  input  logic [tbdp_pkg::LANE_W-1:0] threshold_byte,
  input  logic                        weight_sign,
  input  logic                        lane_on,
  output logic                        hit
);

  logic above;

  assign above = $signed(threshold_byte) > $signed(patch_byte);
  assign hit   = lane_on && (above ^ weight_sign);

endmodule

// ----- src/tbdp_merge.sv -----
`timescale 1ns / 1ps
// lane hit register, popcount of the lanes and the saturating match accumulator
// depends on tbdp_pkg; emits one token per last item toward tbdp_post

module tbdp_merge #(
  parameter  int NLANE        = tbdp_pkg::DEF_LANES,
  parameter  int MAX_ELEMENTS = tbdp_pkg::DEF_MAX_ELEMENTS,
  localparam int ACC_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NLANE-1:0]     lane_hits,
  input  logic                 in_last,
  input  tbdp_pkg::coef_t      in_coef,
  output logic                 tok_valid,
  input  logic                 tok_ready,
  output logic [ACC_W-1:0]     tok_acc,
  output tbdp_pkg::coef_t      tok_coef
);

  localparam int CNT_W = $clog2(NLANE + 1);

  logic                s1_v;
  logic                s1_last;
  logic [NLANE-1:0]    s1_hits;
  tbdp_pkg::coef_t     s1_coef;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_next;
  logic [CNT_W-1:0]    cnt;
  logic [ACC_W:0]      sum;
  logic                consume;

  // a non-last item only feeds the accumulator, so it never waits
  assign consume  = s1_v && (!s1_last || tok_ready);
  assign in_ready = !s1_v || consume;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < NLANE; i++) begin
      cnt = cnt + CNT_W'(s1_hits[i]);
    end
  end

  assign sum = (ACC_W+1)'(acc) + (ACC_W+1)'(cnt);

  always_comb begin
    if (sum > (ACC_W+1)'(MAX_ELEMENTS)) begin
      acc_next = ACC_W'(MAX_ELEMENTS);
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  assign tok_valid = s1_v && s1_last;
  assign tok_acc   = acc_next;
  assign tok_coef  = s1_coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      acc  <= '0;
    end else begin
      if (in_ready) begin
        s1_v <= in_valid;
      end
      if (consume) begin
        acc <= s1_last ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_hits <= lane_hits;
      s1_last <= in_last;
      s1_coef <= in_coef;
    end
  end

  acc_bounded: assert property (@(posedge clk) disable iff (rst)
    acc <= ACC_W'(MAX_ELEMENTS))
    else $error("match accumulator above its saturation limit");

  acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_ready) |=> (acc == '0))
    else $error("accumulator not cleared after a last item");

  stall_on_last: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_v && s1_last && !tok_ready))
    else $error("input stalled without a blocked last item");

endmodule

// ----- src/tbdp_post.sv -----
`timescale 1ns / 1ps
// post stages: dot from match count, q16.16 scale multiply, shift and relu, output register
// depends on tbdp_pkg; takes tokens from tbdp_merge

module tbdp_post #(
  parameter  int MAX_ELEMENTS = tbdp_pkg::DEF_MAX_ELEMENTS,
  localparam int ACC_W        = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  tbdp_pkg::cfg_t      cfg,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  logic [ACC_W-1:0]    tok_acc,
  input  tbdp_pkg::coef_t     tok_coef,
  output logic                out_valid,
  input  logic                out_ready,
  output tbdp_pkg::out_item_t out_item
);

  localparam int HALF_W = (ACC_W + 1 > tbdp_pkg::COUNT_W) ? ACC_W + 1 : tbdp_pkg::COUNT_W;
  localparam int DOT_W  = HALF_W + 1;
  localparam int PROD_W = DOT_W + tbdp_pkg::COEF_W;
  localparam int RES_W  = PROD_W + 1;
  localparam int WIDE_W = RES_W + tbdp_pkg::RESULT_W;
  localparam int MEXT_W = ACC_W + tbdp_pkg::MATCH_W;

  logic                              s2_v, s3_v, s4_v;
  logic                              s2_free, s3_free, s4_free, out_free;
  logic [ACC_W-1:0]                  s2_acc, s3_acc, s4_acc;
  tbdp_pkg::coef_t                   s2_coef, s3_coef;
  logic signed [DOT_W-1:0]           s3_dot, dot_next;
  logic signed [PROD_W-1:0]          s4_prod, prod_next;
  logic signed [tbdp_pkg::COEF_W-1:0] s4_shift, shift_next;
  logic signed [RES_W-1:0]           res_next;
  logic signed [WIDE_W-1:0]          res_wide;
  logic [MEXT_W-1:0]                 match_ext;

  assign out_free  = !out_valid || out_ready;
  assign s4_free   = !s4_v || out_free;
  assign s3_free   = !s3_v || s4_free;
  assign s2_free   = !s2_v || s3_free;
  assign tok_ready = s2_free;

  // dot of the +1/-1 vectors: 2 * matches - element_count
  assign dot_next = $signed(DOT_W'({s2_acc, 1'b0})) - $signed(DOT_W'(cfg.element_count));

  always_comb begin
    if (cfg.scale_enable) begin
      prod_next  = PROD_W'(s3_dot) * PROD_W'(s3_coef.scale_value);
      shift_next = s3_coef.shift_value;
    end else begin
      prod_next  = PROD_W'(s3_dot) <<< tbdp_pkg::FRAC_BITS;
      shift_next = '0;
    end
  end

  always_comb begin
    res_next = RES_W'(s4_prod) + RES_W'(s4_shift);
    if (cfg.relu_enable && res_next[RES_W-1]) begin
      res_next = '0;
    end
  end

  assign res_wide  = WIDE_W'(res_next);
  assign match_ext = MEXT_W'(s4_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_free) s2_v <= tok_valid;
      if (s3_free) s3_v <= s2_v;
      if (s4_free) s4_v <= s3_v;
      if (out_free) out_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid && s2_free) begin
      s2_acc  <= tok_acc;
      s2_coef <= tok_coef;
    end
    if (s2_v && s3_free) begin
      s3_acc  <= s2_acc;
      s3_coef <= s2_coef;
      s3_dot  <= dot_next;
    end
    if (s3_v && s4_free) begin
      s4_acc   <= s3_acc;
      s4_prod  <= prod_next;
      s4_shift <= shift_next;
    end
    if (s4_v && out_free) begin
      out_item.result_value <= res_wide[tbdp_pkg::RESULT_W-1:0];
      out_item.match_total  <= match_ext[tbdp_pkg::MATCH_W-1:0];
    end
  end

  s4_holds: assert property (@(posedge clk) disable iff (rst)
    (s4_v && !out_free) |=> s4_v)
    else $error("multiply stage dropped a result while output was blocked");

  s3_holds: assert property (@(posedge clk) disable iff (rst)
    (s3_v && !s4_free) |=> (s3_v && $stable(s3_dot)))
    else $error("dot stage changed while blocked");

  out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("result transfer changed while waiting");

endmodule

// ----- src/threshold_binary_dot_popcount.sv -----
`timescale 1ns / 1ps
// top level of the thresholded binary dot popcount block
// depends on tbdp_pkg, tbdp_regs, tbdp_lane, tbdp_merge, tbdp_post

// Takes one item per clock while in_ready is high: each item's lanes are
// compared in parallel, their match bits are registered and popcounted into a
// saturating match accumulator in the next cycle, so the accumulate loop sets
// the rate at one item per cycle. Only an item marked last yields a result; it
// passes a dot stage, a multiply stage (dot times Q16.16 scale, or dot times
// 65536) and a shift/relu stage into the output register, and is offered once
// it has moved through the merge register and s2, s3 and s4, which also give
// slack behind the output, so input transfers continue while a result waits;
// in_ready drops only when a last item cannot move on. Configuration goes
// through the APB port and must be written while the block is idle.

module threshold_binary_dot_popcount #(
  parameter int LANES        = tbdp_pkg::DEF_LANES,
  parameter int MAX_ELEMENTS = tbdp_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbdp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tbdp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tbdp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tbdp_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tbdp_pkg::out_item_t             out_item
);

  localparam int NLANE = (LANES < tbdp_pkg::FIELD_LANES) ? LANES : tbdp_pkg::FIELD_LANES;
  localparam int ACC_W = $clog2(MAX_ELEMENTS + 1);

  tbdp_pkg::cfg_t  cfg;
  tbdp_pkg::coef_t in_coef;
  tbdp_pkg::coef_t tok_coef;
  logic [NLANE-1:0] lane_hits;
  logic             tok_valid;
  logic             tok_ready;
  logic [ACC_W-1:0] tok_acc;

  tbdp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    tbdp_lane u_lane (
      .patch_byte     (in_item.patch_bytes[i*tbdp_pkg::LANE_W +: tbdp_pkg::LANE_W]),
      .threshold_byte (in_item.threshold_bytes[i*tbdp_pkg::LANE_W +: tbdp_pkg::LANE_W]),
      .weight_sign    (in_item.weight_signs[i]),
      .lane_on        (in_item.valid_lanes > tbdp_pkg::NLANE_W'(i)),
      .hit            (lane_hits[i])
    );
  end

  assign in_coef.scale_value = in_item.scale_value;
  assign in_coef.shift_value = in_item.shift_value;

  tbdp_merge #(
    .NLANE        (NLANE),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .lane_hits (lane_hits),
    .in_last   (in_item.last),
    .in_coef   (in_coef),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_acc   (tok_acc),
    .tok_coef  (tok_coef)
  );

  tbdp_post #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok_acc   (tok_acc),
    .tok_coef  (tok_coef),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
